FILE: hw/rtl/bdws_pkg.sv
package bdws_pkg;

    localparam int unsigned DEPTH  = 16;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned CAP_W  = 5;
    localparam int unsigned EC_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned KIND_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic grab;
        logic scan;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_valid;
        logic req_pop_read;
        logic req_search;
        logic scan_done;
        logic out_free;
    } stat_t;

    // circular position base + off, with off below DEPTH
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/bdws_ifs.sv
interface bdws_req_if;
    logic                              valid;
    logic                              ready;
    logic [bdws_pkg::KIND_W-1:0]       kind;
    logic signed [bdws_pkg::VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdws_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [bdws_pkg::VAL_W-1:0] data;
    logic                              found;
    logic                              error;
    logic [bdws_pkg::CAP_W-1:0]        count;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output data, output found, output error,
                    output count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input data, input found, input error,
                    input count, input is_empty, input is_full, output ready);
endinterface

interface bdws_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bdws_pkg::CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

FILE: hw/rtl/bounded_deque_with_search_top.sv
// push, pop front, unused kinds and a pop back on an empty list go from the transfer straight to the done state;
// any other pop back passes the read state first (one registered read of the entry store)
// search: the scan state compares one entry per cycle and stops at a match or after the last entry
// a new request is taken only in the idle state, after the previous result is loaded for the receiver;
// a result not yet taken by the receiver holds the next result and the request after it
// reset: asynchronous active low; list empty, head at 0, capacity 16, no result pending
module bounded_deque_with_search_top (
    input  logic       clk,
    input  logic       rst_n,
    bdws_req_if.sink   req,
    bdws_rsp_if.source rsp,
    bdws_cfg_if.sink   cfg
);

    bdws_pkg::cmd_t  cmd;
    bdws_pkg::stat_t stat;

    bdws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    bdws_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

FILE: hw/rtl/bdws_ram.sv
module bdws_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bdws_ctrl.sv
module bdws_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  bdws_pkg::stat_t     stat,
    output bdws_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.req_valid)
                begin
                    priority if (stat.req_pop_read)
                    begin
                        state_next = ST_READ;
                    end
                    else if (stat.req_search)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.grab   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait until the output register can take the result
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bdws_dp.sv
module bdws_dp (
    input  logic                clk,
    input  logic                rst_n,
    bdws_req_if.sink            req,
    bdws_rsp_if.source          rsp,
    bdws_cfg_if.sink            cfg,
    input  bdws_pkg::cmd_t      cmd,
    output bdws_pkg::stat_t     stat
);

    localparam int unsigned ADDR_W = bdws_pkg::ADDR_W;
    localparam int unsigned CNT_W  = bdws_pkg::CNT_W;
    localparam int unsigned EC_W   = bdws_pkg::EC_W;
    localparam int unsigned VAL_W  = bdws_pkg::VAL_W;
    localparam int unsigned CAP_W  = bdws_pkg::CAP_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [ADDR_W-1:0] head_reg,      head_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [VAL_W-1:0]  value_reg,     value_next;
    logic [VAL_W-1:0]  pend_data_reg, pend_data_next;
    logic              pend_found_reg, pend_found_next;
    logic              pend_error_reg, pend_error_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [VAL_W-1:0]  rsp_data_reg;
    logic              rsp_found_reg;
    logic              rsp_error_reg;
    logic [CAP_W-1:0]  rsp_count_reg;
    logic              rsp_empty_reg;
    logic              rsp_full_reg;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic [EC_W-1:0]   cap_ext;
    logic [EC_W-1:0]   eff_cap;
    logic              issue;
    logic              match;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    assign accept  = req.valid && cmd.take;
    assign cap_ext = EC_W'(capacity_reg);

    // zero acts as one, anything above the depth acts as the depth
    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            eff_cap = EC_W'(1);
        end
        else if (cap_ext > EC_W'(bdws_pkg::DEPTH))
        begin
            eff_cap = EC_W'(bdws_pkg::DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign is_empty = (count_reg == '0);
    assign is_full  = (EC_W'(count_reg) >= eff_cap);

    assign issue = (idx_reg < count_reg);
    assign match = cmp_valid_reg && (ram_rdata == value_reg);

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        value_next      = value_reg;
        pend_data_next  = pend_data_reg;
        pend_found_next = pend_found_reg;
        pend_error_next = pend_error_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_raddr       = bdws_pkg::slot_of(head_reg, idx_reg);

        if (accept)
        begin
            value_next      = req.value;
            idx_next        = '0;
            cmp_valid_next  = 1'b0;
            pend_data_next  = '0;
            pend_found_next = 1'b0;
            pend_error_next = 1'b0;
            unique case (req.kind)
                bdws_pkg::KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        pend_error_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = (head_reg == '0) ? ADDR_W'(bdws_pkg::DEPTH - 1)
                                                      : head_reg - ADDR_W'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = head_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bdws_pkg::KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        pend_error_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = bdws_pkg::slot_of(head_reg, count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bdws_pkg::KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        pend_error_next = 1'b1;
                        pend_data_next  = '1;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ram_raddr  = bdws_pkg::slot_of(head_reg, count_next);
                    end
                end
                bdws_pkg::KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        pend_error_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = bdws_pkg::slot_of(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.grab)
        begin
            pend_data_next = ram_rdata;
        end

        // one read issued and one compare made per cycle
        if (cmd.scan)
        begin
            cmp_valid_next = issue && !match;
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (match)
            begin
                pend_found_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.req_valid    = req.valid;
        stat.req_pop_read = (req.kind == bdws_pkg::KIND_POP_BACK) && !is_empty;
        stat.req_search   = (req.kind == bdws_pkg::KIND_SEARCH);
        stat.scan_done    = match || !issue;
        stat.out_free     = !rsp_valid_reg || rsp.ready;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    bdws_ram #(
        .WIDTH (VAL_W),
        .DEPTH (bdws_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= bdws_pkg::CAP_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                capacity_reg <= cfg.capacity;
            end
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        pend_data_reg  <= pend_data_next;
        pend_found_reg <= pend_found_next;
        pend_error_reg <= pend_error_next;
        if (cmd.finish)
        begin
            rsp_data_reg  <= pend_data_reg;
            rsp_found_reg <= pend_found_reg;
            rsp_error_reg <= pend_error_reg;
            rsp_count_reg <= CAP_W'(count_reg);
            rsp_empty_reg <= is_empty;
            rsp_full_reg  <= is_full;
        end
    end

    assign req.ready    = cmd.take;
    assign cfg.ready    = 1'b1;
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.data     = rsp_data_reg;
    assign rsp.found    = rsp_found_reg;
    assign rsp.error    = rsp_error_reg;
    assign rsp.count    = rsp_count_reg;
    assign rsp.is_empty = rsp_empty_reg;
    assign rsp.is_full  = rsp_full_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(bdws_pkg::DEPTH))
        else $error("held count above depth");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg) && $stable(head_reg))
        else $error("list state moved without an accepted request");

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp_valid_reg || rsp.ready))
        else $error("result loaded over an untaken result");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !is_full && accept)
        else $error("entry written on a full list");
`endif

endmodule
